// ===== hw/rtl/rhh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared types, constants and helpers of the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int CAPACITY  = 256;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int PSL_W     = 8;
    localparam int MAX_PROBE = 255;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int KEY_BYTES = 8;
    localparam int VALUE_W   = 32;
    localparam int HASH_W    = 32;
    localparam int COUNT_W   = 9;

    localparam logic [31:0] SEED_RESET = 32'h9747b28c;
    localparam logic [8:0]  FILL_RESET = 9'd192;
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RES_UPDATED  = 3'd0,
        RES_INSERTED = 3'd1,
        RES_FOUND    = 3'd2,
        RES_REMOVED  = 3'd3,
        RES_NOTFOUND = 3'd4,
        RES_FULL     = 3'd5,
        RES_PLIMIT   = 3'd6,
        RES_CLEARED  = 3'd7
    } status_t;

    typedef enum logic {
        CFG_SEED = 1'b0,
        CFG_FILL = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_FIND_RD,
        S_FIND_EV,
        S_INS_RD,
        S_INS_EV,
        S_RESP
    } state_t;

    typedef struct packed {
        logic               tomb;
        logic [PSL_W-1:0]   psl;
        logic [KEY_W-1:0]   key;
        logic [LEN_W-1:0]   klen;
        logic [HASH_W-1:0]  hash;
        logic [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== hw/rtl/rhh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/rhh_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_hash
// Sequential 32-bit MurmurHash3 of a key of up to 8 bytes.
// ----------------------------------------------------------------------------
module rhh_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rhh_pkg::KEY_W-1:0] key,
    input  logic [rhh_pkg::LEN_W-1:0] key_len,
    input  logic [31:0]               seed,
    output logic                      done,
    output logic [31:0]               hash
);

    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] blk;
    logic [31:0] t;
    logic [1:0]  bidx;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        h_next    = h_reg;
        k_next    = k_reg;
        bidx      = (step_reg < 4'd3) ? 2'd0 : 2'd1;
        blk       = (step_reg < 4'd3) ? key[31:0] : key[63:32];
        t         = 32'd0;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = 4'd0;
                h_next    = seed;
            end
        end
        else
        begin
            step_next = step_reg + 4'd1;
            case (step_reg)
                4'd0, 4'd3: k_next = rhh_pkg::mul32(blk, rhh_pkg::C1);
                4'd1, 4'd4: k_next = rhh_pkg::mul32(rhh_pkg::rotl(k_reg, 15), rhh_pkg::C2);
                4'd2, 4'd5:
                begin
                    // A full block mixes into h; a partial tail only folds in.
                    if (bidx < key_len[3:2])
                    begin
                        t      = rhh_pkg::rotl(h_reg ^ k_reg, 13);
                        h_next = (t << 2) + t + rhh_pkg::C3;
                    end
                    else if (bidx == key_len[3:2] && key_len[1:0] != 2'd0)
                    begin
                        h_next = h_reg ^ k_reg;
                    end
                end
                4'd6:
                begin
                    t      = h_reg ^ {28'd0, key_len};
                    t      = t ^ (t >> 16);
                    h_next = rhh_pkg::mul32(t, rhh_pkg::F1);
                end
                4'd7:
                begin
                    t      = h_reg ^ (h_reg >> 13);
                    h_next = rhh_pkg::mul32(t, rhh_pkg::F2);
                end
                default:
                begin
                    h_next    = h_reg ^ (h_reg >> 16);
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        k_reg <= k_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

// ===== hw/rtl/robin_hood_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Fixed-capacity Robin Hood hash table with MurmurHash3 keys.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the operation (put,
// get, remove, clear), tdata the key, key length and value. Every request
// gives exactly one response on m_axis with status, value and live count.
// One request is in work at a time. A clear goes straight from acceptance to
// the response state. Other requests first pass through the hash unit, then
// read and evaluate each probed slot on the single read port of the slot RAM,
// and an insert reads and evaluates each further slot it walks before going
// to the response state.
// The response sits in an output register; the next request is accepted from
// the following cycle while it waits, and a stalled receiver holds that
// request at its end.
// Reset empties the table at once through per-slot occupied flags, sets the
// seed and fill limit to their defaults, and needs no clearing pass.
// Configuration writes on cfg_* are always accepted and must only be made
// while no request is in work.
// ----------------------------------------------------------------------------
module robin_hood_hash_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_bytes[63:0], key_length[67:64], put_value[99:68], zero fill
    input  logic [103:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], result_value[34:3], live_entries[43:35], zero fill
    output logic [47:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = rhh_pkg::ADDR_W;
    localparam int CW = rhh_pkg::COUNT_W;

    rhh_pkg::state_t  state_reg, state_next;
    rhh_pkg::op_t     op_reg, op_next;
    rhh_pkg::status_t status_reg, status_next;
    rhh_pkg::entry_t  carry_reg, carry_next;
    rhh_pkg::entry_t  rd;
    rhh_pkg::entry_t  wr_data;

    logic [rhh_pkg::KEY_W-1:0]   key_reg, key_next, key_in;
    logic [rhh_pkg::LEN_W-1:0]   len_reg, len_next, len_in;
    logic [rhh_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [rhh_pkg::VALUE_W-1:0] res_reg, res_next;
    logic [31:0]                 hash_reg, hash_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               psl_reg, psl_next;
    logic [CW-1:0]               n_reg, n_next;
    logic [CW-1:0]               live_reg, live_next;
    logic [CW-1:0]               tomb_reg, tomb_next;
    logic [31:0]                 seed_reg;
    logic [8:0]                  fill_reg;
    logic [rhh_pkg::CAPACITY-1:0] occ_reg, occ_next;
    logic                        m_valid_reg;
    logic [47:0]                 m_data_reg;

    logic          s_fire;
    logic          hash_done;
    logic [31:0]   hash_out;
    logic          wr_en;
    logic [rhh_pkg::ENTRY_W-1:0] rd_raw;
    logic          occ;
    logic          live_hit;
    logic          psl_stop;
    logic          match;
    logic          is_full;
    logic [CW:0]   need;
    logic [CW-1:0] psl_inc;
    logic [CW-1:0] n_inc;
    logic          out_free;

    assign s_axis_tready = (state_reg == rhh_pkg::S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Clamp the length and zero every key byte past it.
    always_comb
    begin
        len_in = s_axis_tdata[67:64];
        if (len_in > 4'(rhh_pkg::KEY_BYTES))
        begin
            len_in = 4'(rhh_pkg::KEY_BYTES);
        end
        for (int i = 0; i < rhh_pkg::KEY_BYTES; i++)
        begin
            key_in[8*i +: 8] = (4'(i) < len_in) ? s_axis_tdata[8*i +: 8] : 8'd0;
        end
    end

    rhh_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == rhh_pkg::S_HASH && !hash_done),
        .key     (key_reg),
        .key_len (len_reg),
        .seed    (seed_reg),
        .done    (hash_done),
        .hash    (hash_out)
    );

    rhh_ram #(
        .WIDTH (rhh_pkg::ENTRY_W),
        .DEPTH (rhh_pkg::CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_raw)
    );

    assign rd = rd_raw;

    // Probe decisions on the slot read back for idx_reg.
    always_comb
    begin
        occ      = occ_reg[idx_reg];
        live_hit = occ && !rd.tomb;
        psl_stop = psl_reg > {1'b0, rd.psl};
        match    = (rd.hash == hash_reg) && (rd.klen == len_reg) && (rd.key == key_reg);
        need     = {1'b0, live_reg} + {1'b0, tomb_reg} + (CW+1)'(1);
        is_full  = (need > {1'b0, fill_reg}) || (need > (CW+1)'(rhh_pkg::CAPACITY));
        psl_inc  = psl_reg + CW'(1);
        n_inc    = n_reg + CW'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rhh_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = (rhh_pkg::op_t'(s_axis_tuser) == rhh_pkg::OP_CLEAR) ?
                                 rhh_pkg::S_RESP : rhh_pkg::S_HASH;
                end
            end
            rhh_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = rhh_pkg::S_FIND_RD;
                end
            end
            rhh_pkg::S_FIND_RD: state_next = rhh_pkg::S_FIND_EV;
            rhh_pkg::S_FIND_EV:
            begin
                if (!occ || (live_hit && (psl_stop || match)))
                begin
                    if (!occ || psl_stop)
                    begin
                        state_next = (op_reg == rhh_pkg::OP_PUT && !is_full) ?
                                     rhh_pkg::S_INS_RD : rhh_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = rhh_pkg::S_RESP;
                    end
                end
                else if (psl_inc > CW'(rhh_pkg::MAX_PROBE))
                begin
                    state_next = rhh_pkg::S_RESP;
                end
                else
                begin
                    state_next = rhh_pkg::S_FIND_RD;
                end
            end
            rhh_pkg::S_INS_RD: state_next = rhh_pkg::S_INS_EV;
            rhh_pkg::S_INS_EV:
            begin
                if (!live_hit || n_inc == CW'(rhh_pkg::CAPACITY))
                begin
                    state_next = rhh_pkg::S_RESP;
                end
                else
                begin
                    state_next = rhh_pkg::S_INS_RD;
                end
            end
            rhh_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = rhh_pkg::S_IDLE;
                end
            end
            default: state_next = rhh_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        key_next    = key_reg;
        len_next    = len_reg;
        val_next    = val_reg;
        hash_next   = hash_reg;
        idx_next    = idx_reg;
        psl_next    = psl_reg;
        n_next      = n_reg;
        carry_next  = carry_reg;
        status_next = status_reg;
        res_next    = res_reg;
        live_next   = live_reg;
        tomb_next   = tomb_reg;
        occ_next    = occ_reg;
        wr_en       = 1'b0;
        wr_data     = rd;
        unique case (state_reg)
            rhh_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    op_next  = rhh_pkg::op_t'(s_axis_tuser);
                    key_next = key_in;
                    len_next = len_in;
                    val_next = s_axis_tdata[99:68];
                    res_next = '0;
                    if (rhh_pkg::op_t'(s_axis_tuser) == rhh_pkg::OP_CLEAR)
                    begin
                        occ_next    = '0;
                        live_next   = '0;
                        tomb_next   = '0;
                        status_next = rhh_pkg::RES_CLEARED;
                    end
                end
            end
            rhh_pkg::S_HASH:
            begin
                hash_next = hash_out;
                idx_next  = hash_out[AW-1:0];
                psl_next  = '0;
            end
            rhh_pkg::S_FIND_EV:
            begin
                if (!occ || (live_hit && psl_stop))
                begin
                    status_next = rhh_pkg::RES_NOTFOUND;
                    if (op_reg == rhh_pkg::OP_PUT)
                    begin
                        status_next = is_full ? rhh_pkg::RES_FULL : rhh_pkg::RES_INSERTED;
                        idx_next    = hash_reg[AW-1:0];
                        n_next      = '0;
                        carry_next  = '{tomb: 1'b0, psl: '0, key: key_reg, klen: len_reg,
                                        hash: hash_reg, value: val_reg};
                    end
                end
                else if (live_hit && match)
                begin
                    unique case (op_reg)
                        rhh_pkg::OP_PUT:
                        begin
                            wr_en         = 1'b1;
                            wr_data.value = val_reg;
                            status_next   = rhh_pkg::RES_UPDATED;
                        end
                        rhh_pkg::OP_GET:
                        begin
                            res_next    = rd.value;
                            status_next = rhh_pkg::RES_FOUND;
                        end
                        default:
                        begin
                            wr_en        = 1'b1;
                            wr_data.tomb = 1'b1;
                            res_next     = rd.value;
                            status_next  = rhh_pkg::RES_REMOVED;
                            tomb_next    = tomb_reg + CW'(1);
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - CW'(1);
                            end
                        end
                    endcase
                end
                else
                begin
                    idx_next    = idx_reg + AW'(1);
                    psl_next    = psl_inc;
                    status_next = rhh_pkg::RES_PLIMIT;
                end
            end
            rhh_pkg::S_INS_EV:
            begin
                if (!live_hit)
                begin
                    // Empty slot or tombstone: the carried entry lands here.
                    wr_en     = 1'b1;
                    wr_data   = carry_reg;
                    occ_next[idx_reg] = 1'b1;
                    live_next = live_reg + CW'(1);
                    if (occ && tomb_reg != '0)
                    begin
                        tomb_next = tomb_reg - CW'(1);
                    end
                end
                else
                begin
                    if (rd.psl < carry_reg.psl)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = carry_reg;
                        carry_next = rd;
                    end
                    if (carry_next.psl != {rhh_pkg::PSL_W{1'b1}})
                    begin
                        carry_next.psl = carry_next.psl + rhh_pkg::PSL_W'(1);
                    end
                    idx_next = idx_reg + AW'(1);
                    n_next   = n_inc;
                    if (n_inc == CW'(rhh_pkg::CAPACITY))
                    begin
                        live_next = live_reg + CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rhh_pkg::S_IDLE;
            live_reg    <= '0;
            tomb_reg    <= '0;
            occ_reg     <= '0;
            seed_reg    <= rhh_pkg::SEED_RESET;
            fill_reg    <= rhh_pkg::FILL_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            tomb_reg  <= tomb_next;
            occ_reg   <= occ_next;
            if (cfg_valid)
            begin
                unique case (rhh_pkg::cfg_idx_t'(cfg_index))
                    rhh_pkg::CFG_SEED: seed_reg <= cfg_data;
                    rhh_pkg::CFG_FILL: fill_reg <= cfg_data[8:0];
                    default: seed_reg <= seed_reg;
                endcase
            end
            if (state_reg == rhh_pkg::S_RESP && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        len_reg    <= len_next;
        val_reg    <= val_next;
        hash_reg   <= hash_next;
        idx_reg    <= idx_next;
        psl_reg    <= psl_next;
        n_reg      <= n_next;
        carry_reg  <= carry_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        if (state_reg == rhh_pkg::S_RESP && out_free)
        begin
            m_data_reg <= {4'd0, live_reg, res_reg, status_reg};
        end
    end

endmodule
